@@ src/sdl_pkg.sv @@
// Shared types, widths and constants for the switch debouncer with hold timer.
package sdl_pkg;

  localparam int unsigned TickW     = 10;
  localparam int unsigned PeriodW   = 10;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned SelW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SelSpan   = 1 << SelW;

  localparam logic [TickW-1:0]   TickReset   = TickW'(5);
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(20);
  localparam logic [HoldW-1:0]   HoldReset   = HoldW'(3000);
  localparam logic [SelW-1:0]    SelReset    = SelW'(2);

  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TICK_MS        = 2'd0,
    REG_SAMPLE_PERIOD  = 2'd1,
    REG_HOLD_TIME      = 2'd2,
    REG_HOLD_SWITCH    = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_RELEASED     = 4'b0001,
    ST_PRE_PRESSED  = 4'b0010,
    ST_PRESSED      = 4'b0100,
    ST_PRE_RELEASED = 4'b1000
  } deb_state_e;

  typedef enum logic [1:0] {
    CODE_RELEASED     = 2'd0,
    CODE_PRE_PRESSED  = 2'd1,
    CODE_PRESSED      = 2'd2,
    CODE_PRE_RELEASED = 2'd3
  } state_code_e;

  typedef struct packed {
    logic accept;
    logic sample;
    logic clear;
  } sdl_tick_t;

  function automatic state_code_e state_code(deb_state_e st);
    state_code_e code;
    unique case (st)
      ST_RELEASED:     code = CODE_RELEASED;
      ST_PRE_PRESSED:  code = CODE_PRE_PRESSED;
      ST_PRESSED:      code = CODE_PRESSED;
      ST_PRE_RELEASED: code = CODE_PRE_RELEASED;
      default:         code = CODE_RELEASED;
    endcase
    return code;
  endfunction

endpackage

@@ src/sdl_in_if.sv @@
// Tick request channel: raw switch levels and the flag clear.
interface sdl_in_if #(
  parameter int unsigned NUM_SWITCHES = 3
);
  logic                    valid;
  logic                    ready;
  logic [NUM_SWITCHES-1:0] raw_levels;
  logic                    clear_long_press;

  modport source (output valid, output raw_levels, output clear_long_press, input ready);
  modport sink   (input valid, input raw_levels, input clear_long_press, output ready);
endinterface

@@ src/sdl_out_if.sv @@
// Result channel: debounced states, long-press flag and sample marker.
interface sdl_out_if #(
  parameter int unsigned NUM_SWITCHES = 3
);
  logic                      valid;
  logic                      ready;
  logic [2*NUM_SWITCHES-1:0] switch_states;
  logic                      long_press_flag;
  logic                      sampled_now;

  modport source (output valid, output switch_states, output long_press_flag,
                  output sampled_now, input ready);
  modport sink   (input valid, input switch_states, input long_press_flag,
                  input sampled_now, output ready);
endinterface

@@ src/switch_debounce_long_press_unit.sv @@
// Switch debouncer top: one tick per cycle while intake is ready, each result held in the output buffer.
// An accepted request's result is registered in the output register, or in the skid slot on a stall.
// Throughput: one request per cycle while the skid slot is free; it holds one stalled result.
// Each accepted tick updates the prescaler; a sampling tick also steps all lanes and the hold timer.
// Reset: registers to defaults, switches released at released level, counters and flag clear.
module switch_debounce_long_press_unit #(
  parameter int unsigned NUM_SWITCHES = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  sdl_in_if.sink                        in_if,
  sdl_out_if.source                     out_if
);
  import sdl_pkg::*;

  localparam int unsigned ResW = 2*NUM_SWITCHES + 2;

  logic [TickW-1:0]   tick_q;
  logic [PeriodW-1:0] period_q;
  logic [HoldW-1:0]   hold_time_q;
  logic [SelW-1:0]    hold_sel_q;

  logic [PeriodW-1:0] pre_q, pre_d;
  logic [PeriodW:0]   pre_sum;
  logic               in_ready, accept, sample;
  sdl_tick_t          tick;

  logic [2*NUM_SWITCHES-1:0] codes;
  logic [ResW-1:0]           result, out_data;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= TickReset;
      period_q    <= PeriodReset;
      hold_time_q <= HoldReset;
      hold_sel_q  <= SelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TICK_MS:       tick_q      <= cfg_wdata_i[TickW-1:0];
        REG_SAMPLE_PERIOD: period_q    <= cfg_wdata_i[PeriodW-1:0];
        REG_HOLD_TIME:     hold_time_q <= cfg_wdata_i[HoldW-1:0];
        REG_HOLD_SWITCH:   hold_sel_q  <= cfg_wdata_i[SelW-1:0];
        default:           tick_q      <= tick_q;
      endcase
    end
  end

  assign accept = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // prescaler: a stored count is always below 1024, so the wider sum never wraps
  assign pre_sum = {1'b0, pre_q} + (PeriodW+1)'(tick_q);
  assign sample  = (pre_sum >= {1'b0, period_q});

  always_comb begin
    pre_d = pre_q;
    if (accept) pre_d = sample ? '0 : pre_sum[PeriodW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pre_q <= '0;
    else         pre_q <= pre_d;
  end

  assign tick.accept = accept;
  assign tick.sample = sample;
  assign tick.clear  = in_if.clear_long_press;

  for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
    sdl_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .sample_en_i (accept && sample),
      .level_i     (in_if.raw_levels[i]),
      .code_o      (codes[2*i +: 2])
    );
  end

  sdl_merge #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .codes_i       (codes),
    .period_i      (period_q),
    .hold_time_i   (hold_time_q),
    .hold_switch_i (hold_sel_q),
    .result_o      (result)
  );

  sdl_out_buf #(
    .WIDTH (ResW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (in_ready),
    .valid_o     (out_if.valid),
    .pop_ready_i (out_if.ready),
    .data_o      (out_data)
  );

  assign out_if.switch_states   = out_data[ResW-1:2];
  assign out_if.long_press_flag = out_data[1];
  assign out_if.sampled_now     = out_data[0];

endmodule

@@ src/sdl_lane.sv @@
// One switch lane: four-state debouncer stepped on each sample.
module sdl_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_en_i,
  input  logic               level_i,
  output logic [1:0]         code_o
);
  import sdl_pkg::*;

  deb_state_e state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    if (sample_en_i) begin
      last_d = level_i;
      unique case (state_q)
        ST_RELEASED: begin
          if (last_q == LevelPressed && level_i == LevelPressed) state_d = ST_PRE_PRESSED;
        end
        ST_PRE_PRESSED: begin
          if (level_i == LevelPressed) state_d = ST_PRESSED;
        end
        ST_PRESSED: begin
          if (last_q == LevelReleased && level_i == LevelReleased) state_d = ST_PRE_RELEASED;
        end
        ST_PRE_RELEASED: begin
          if (level_i == LevelReleased) state_d = ST_RELEASED;
        end
        default: state_d = ST_RELEASED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RELEASED;
      last_q  <= LevelReleased;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // state after this tick, as the result needs it
  assign code_o = state_code(state_d);

endmodule

@@ src/sdl_merge.sv @@
// Merge stage: packs lane states and runs the hold timer and sticky flag.
module sdl_merge #(
  parameter int unsigned NUM_SWITCHES = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdl_pkg::sdl_tick_t            tick_i,
  input  logic [2*NUM_SWITCHES-1:0]     codes_i,
  input  logic [sdl_pkg::PeriodW-1:0]   period_i,
  input  logic [sdl_pkg::HoldW-1:0]     hold_time_i,
  input  logic [sdl_pkg::SelW-1:0]      hold_switch_i,
  output logic [2*NUM_SWITCHES+1:0]     result_o
);
  import sdl_pkg::*;

  logic [SelSpan-1:0] pressed_vec;
  logic               watched_pressed;
  logic [HoldW:0]     hold_sum;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic               flag_q, flag_d;

  // watch positions beyond the switch count never read as pressed
  for (genvar k = 0; k < SelSpan; k++) begin : g_watch
    if (k < NUM_SWITCHES) begin : g_real
      assign pressed_vec[k] = (codes_i[2*k +: 2] == CODE_PRESSED);
    end else begin : g_none
      assign pressed_vec[k] = 1'b0;
    end
  end

  assign watched_pressed = pressed_vec[hold_switch_i];
  assign hold_sum        = {1'b0, hold_q} + (HoldW+1)'(period_i);

  always_comb begin
    hold_d = hold_q;
    flag_d = flag_q;
    if (tick_i.accept) begin
      // clear first so a flag set by this sample survives
      if (tick_i.clear) flag_d = 1'b0;
      if (tick_i.sample) begin
        if (watched_pressed) begin
          if (hold_sum >= {1'b0, hold_time_i}) begin
            flag_d = 1'b1;
            hold_d = '0;
          end else begin
            hold_d = hold_sum[HoldW-1:0];
          end
        end else begin
          hold_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      flag_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      flag_q <= flag_d;
    end
  end

  assign result_o = {codes_i, flag_d, tick_i.sample};

endmodule

@@ src/sdl_out_buf.sv @@
// Two-entry output buffer: result register plus skid slot.
module sdl_out_buf #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] data_o
);
  logic             main_v_q, main_v_d, skid_v_q, skid_v_d;
  logic [WIDTH-1:0] main_q, main_d, skid_q, skid_d;
  logic             pop;

  assign pop = main_v_q && pop_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop) begin
      main_v_d = skid_v_q;
      main_d   = skid_q;
      skid_v_d = 1'b0;
    end
    if (push_i) begin
      if (!main_v_d) begin
        main_v_d = 1'b1;
        main_d   = data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

@@ tb/sv/tb_switch_debounce_long_press_unit.sv @@
// Testbench for the switch debouncer with hold timer: predicts each tick and checks every result.
module tb_switch_debounce_long_press_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sdl_pkg::*;

  localparam int unsigned NSW        = 3;
  localparam int unsigned LongHold   = 48;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [2*NSW-1:0] switch_states;
    logic             long_press_flag;
    logic             sampled_now;
  } debounce_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sdl_in_if  #(.NUM_SWITCHES(NSW)) tick_ch ();
  sdl_out_if #(.NUM_SWITCHES(NSW)) result_ch ();

  switch_debounce_long_press_unit #(.NUM_SWITCHES(NSW)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (tick_ch),
    .out_if     (result_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted copy of the block's registers and state
  logic [TickW-1:0]   tick_cfg;
  logic [PeriodW-1:0] period_cfg;
  logic [HoldW-1:0]   hold_cfg;
  logic [SelW-1:0]    sel_cfg;
  logic [15:0]        prescale;
  logic [NSW-1:0]     last_lv;
  state_code_e        deb_st [NSW];
  logic [15:0]        hold_cnt;
  logic               lp_flag;

  debounce_result_t expected_results [$];
  debounce_result_t oldest_expected;

  logic [NSW-1:0] switch_target = '1;
  bit             sender_idle;
  bit             sink_idle;
  bit             sink_hold_req;
  bit             sink_hold_seen;
  int unsigned    sink_hold_left;
  int unsigned    stall_left;
  int unsigned    cycle_cnt;
  int unsigned    error_cnt;
  int unsigned    sent_cnt;
  int unsigned    result_cnt;
  int unsigned    sampled_cnt;
  int unsigned    flagged_cnt;
  int unsigned    phase_cnt;

  function automatic void reset_debounce_model();
    int i;
    tick_cfg   = TickReset;
    period_cfg = PeriodReset;
    hold_cfg   = HoldReset;
    sel_cfg    = SelReset;
    prescale   = '0;
    last_lv    = '1;
    for (i = 0; i < NSW; i++) deb_st[i] = CODE_RELEASED;
    hold_cnt   = '0;
    lp_flag    = 1'b0;
  endfunction

  function automatic state_code_e next_code(state_code_e st, logic prev, logic now);
    state_code_e nxt;
    nxt = st;
    case (st)
      CODE_RELEASED: begin
        if (prev == LevelPressed && now == LevelPressed) nxt = CODE_PRE_PRESSED;
      end
      CODE_PRE_PRESSED: begin
        if (now == LevelPressed) nxt = CODE_PRESSED;
      end
      CODE_PRESSED: begin
        if (prev == LevelReleased && now == LevelReleased) nxt = CODE_PRE_RELEASED;
      end
      default: begin
        if (now == LevelReleased) nxt = CODE_RELEASED;
      end
    endcase
    return nxt;
  endfunction

  // Advance the prescaler, the flag clear and the lanes by one tick
  function automatic debounce_result_t advance_tick(logic [NSW-1:0] lv, logic clr);
    debounce_result_t r;
    int               i;
    r = '0;
    if (clr) lp_flag = 1'b0;
    prescale = prescale + 16'(tick_cfg);
    if (prescale >= 16'(period_cfg)) begin
      prescale      = '0;
      r.sampled_now = 1'b1;
      for (i = 0; i < NSW; i++) begin
        deb_st[i]  = next_code(deb_st[i], last_lv[i], lv[i]);
        last_lv[i] = lv[i];
      end
    end
    return r;
  endfunction

  // Hold timer kept apart so it runs on the count from before this sample
  function automatic debounce_result_t tick_with_timer(logic [NSW-1:0] lv, logic clr);
    debounce_result_t r;
    logic [15:0]      prev_hold;
    logic [31:0]      held;
    int               i;
    prev_hold = hold_cnt;
    r = advance_tick(lv, clr);
    if (r.sampled_now) begin
      hold_cnt = '0;
      if (int'(sel_cfg) < NSW) begin
        if (deb_st[sel_cfg] == CODE_PRESSED) begin
          held = 32'(prev_hold) + 32'(period_cfg);
          if (held >= 32'(hold_cfg)) lp_flag = 1'b1;
          else hold_cnt = held[15:0];
        end
      end
    end else begin
      hold_cnt = prev_hold;
    end
    for (i = 0; i < NSW; i++) r.switch_states[2*i +: 2] = deb_st[i];
    r.long_press_flag = lp_flag;
    return r;
  endfunction

  // Write all four registers, one per edge; the block must be idle
  task automatic set_config(logic [CfgDataW-1:0] tick, logic [CfgDataW-1:0] period,
                            logic [CfgDataW-1:0] hold, logic [CfgDataW-1:0] sel);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TICK_MS;
    cfg_wdata_i <= tick;
    @(posedge clk_i);
    tick_cfg     = tick[TickW-1:0];
    cfg_idx_i   <= REG_SAMPLE_PERIOD;
    cfg_wdata_i <= period;
    @(posedge clk_i);
    period_cfg   = period[PeriodW-1:0];
    cfg_idx_i   <= REG_HOLD_TIME;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    hold_cfg     = hold[HoldW-1:0];
    cfg_idx_i   <= REG_HOLD_SWITCH;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    sel_cfg      = sel[SelW-1:0];
    cfg_we_i    <= 1'b0;
    phase_cnt++;
  endtask

  task automatic send_tick(logic [NSW-1:0] lv, logic clr);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    tick_ch.valid            <= 1'b1;
    tick_ch.raw_levels       <= lv;
    tick_ch.clear_long_press <= clr;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    expected_results.push_back(tick_with_timer(lv, clr));
    sent_cnt++;
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Switches mostly hold their level for a while, with the odd bounce
  task automatic send_random_ticks(int unsigned count);
    logic [NSW-1:0] lv;
    logic [NSW-1:0] glitch;
    int             i;
    int             n;
    for (n = 0; n < count; n++) begin
      glitch = '0;
      for (i = 0; i < NSW; i++) begin
        if ($urandom_range(0, 5) == 0) switch_target[i] = ~switch_target[i];
        if ($urandom_range(0, 11) == 0) glitch[i] = 1'b1;
      end
      if ($urandom_range(0, 9) < 2) lv = NSW'($urandom_range(0, 7));
      else lv = switch_target ^ glitch;
      send_tick(lv, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic test_reset_defaults();
    logic [NSW-1:0] levels [8] = '{3'b111, 3'b000, 3'b000, 3'b000,
                                    3'b000, 3'b000, 3'b101, 3'b111};
    int             n;
    for (n = 0; n < 8; n++) send_tick(levels[n], n == 0 || n == 5);
    settle();
  endtask

  task automatic test_special_cases();
    // zero period samples every tick, zero hold time flags the first pressed sample
    set_config(16'd1, 16'd0, 16'd0, 16'd0);
    send_tick(3'b110, 1'b0);
    send_tick(3'b110, 1'b0);
    send_tick(3'b110, 1'b0);
    send_tick(3'b110, 1'b1);
    settle();
    // no switch watched: the flag clears and stays clear
    set_config(16'd1, 16'd0, 16'd0, 16'd3);
    send_tick(3'b110, 1'b1);
    send_tick(3'b000, 1'b0);
    send_tick(3'b111, 1'b0);
    send_tick(3'b111, 1'b0);
    send_tick(3'b111, 1'b0);
    settle();
    // upper write bits dropped: tick 500, period 1023, hold 65535, switch 2
    set_config(16'hFDF4, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_tick(3'b000, 1'b0);
    send_tick(3'b000, 1'b0);
    settle();
    // period lowered below the count: next tick samples
    set_config(16'hFDF4, 16'd100, 16'hFFFF, 16'hFFFE);
    send_tick(3'b000, 1'b1);
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned p;
    int unsigned tick;
    int unsigned period;
    int unsigned hold;
    int unsigned sel;
    for (p = 0; p < 8; p++) begin
      sel = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
      case (p % 4)
        0: begin
          tick   = $urandom_range(1, 50);
          period = tick;
          hold   = $urandom_range(0, 8) * period;
        end
        1: begin
          tick   = $urandom_range(1, 10);
          period = tick * $urandom_range(2, 4);
          hold   = $urandom_range(0, 300);
        end
        2: begin
          tick   = 1023;
          period = (p == 2) ? 1 : 1023;
          hold   = (p == 2) ? 1 : 65535;
        end
        default: begin
          tick   = $urandom_range(0, 1023);
          period = $urandom_range(0, 1023);
          hold   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 2000);
        end
      endcase
      set_config(CfgDataW'(tick), CfgDataW'(period), CfgDataW'(hold), CfgDataW'(sel));
      send_random_ticks(70);
      settle();
    end
  endtask

  // Receiver holds off while requests keep coming, so intake must stall
  task automatic test_backpressure();
    set_config(16'd1, 16'd1, 16'd3, 16'd1);
    sender_idle   = 1'b0;
    sink_hold_req = 1'b1;
    send_random_ticks(30);
    settle();
    sink_hold_req = 1'b0;
    sender_idle   = 1'b1;
  endtask

  task automatic test_steady_tail();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    set_config(16'd7, 16'd7, 16'd21, 16'd2);
    send_random_ticks(60);
    settle();
  endtask

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    error_cnt++;
    if (error_cnt <= 10) begin
      $display("mismatch on %s in result %0d: expected %0d, got %0d",
               field, result_cnt, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (sink_hold_left != 0) begin
      result_ch.ready <= 1'b0;
      sink_hold_left--;
    end else if (sink_hold_req && !sink_hold_seen) begin
      result_ch.ready <= 1'b0;
      sink_hold_left = LongHold - 1;
      sink_hold_seen = 1'b1;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unrequested result", 0, 1);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (result_ch.switch_states !== oldest_expected.switch_states)
          note_mismatch("switch_states", oldest_expected.switch_states,
                        result_ch.switch_states);
        if (result_ch.long_press_flag !== oldest_expected.long_press_flag)
          note_mismatch("long_press_flag", oldest_expected.long_press_flag,
                        result_ch.long_press_flag);
        if (result_ch.sampled_now !== oldest_expected.sampled_now)
          note_mismatch("sampled_now", oldest_expected.sampled_now,
                        result_ch.sampled_now);
        if (oldest_expected.sampled_now) sampled_cnt++;
        if (oldest_expected.long_press_flag) flagged_cnt++;
      end
      result_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL switch_debounce_long_press_unit");
      $finish;
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = REG_TICK_MS;
    cfg_wdata_i              = '0;
    tick_ch.valid            = 1'b0;
    tick_ch.raw_levels       = '1;
    tick_ch.clear_long_press = 1'b0;
    sender_idle              = 1'b1;
    sink_idle                = 1'b1;
    reset_debounce_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_special_cases();
    test_random_phases();
    test_backpressure();
    test_steady_tail();

    if (expected_results.size() != 0)
      $display("%0d results never arrived", expected_results.size());
    $display("Run covered %0d requests and %0d results over %0d register settings;",
             sent_cnt, result_cnt, phase_cnt);
    $display("%0d results carried a sample and %0d showed the long-press flag set.",
             sampled_cnt, flagged_cnt);
    if (error_cnt == 0 && expected_results.size() == 0) begin
      $display("PASS switch_debounce_long_press_unit");
    end else begin
      $display("FAIL switch_debounce_long_press_unit");
    end
    $finish;
  end

endmodule
